// ===== src/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// pit_pkg
// Shared widths, payload types and intermediate bundles for the
// point-in-triangle test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

    // coordinate and derived widths
    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;   // edge vector component
    localparam int PROD_W     = 2 * DIFF_W;       // product of two components
    localparam int DOT_W      = PROD_W + 2;       // sum of three products
    localparam int HALF_W     = DOT_W / 2;        // split point for wide multiply
    localparam int PART_W     = 2 * (HALF_W + 1); // partial product width
    localparam int WIDE_W     = 2 * DOT_W + 2;    // products of dots and their sums

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [DOT_W-1:0]      dot_t;
    typedef logic signed [HALF_W:0]       half_t;
    typedef logic signed [PART_W-1:0]     part_t;
    typedef logic signed [WIDE_W-1:0]     wide_t;

    // request payload: test point and three corners
    typedef struct packed {
        coord_t test_x;
        coord_t test_y;
        coord_t test_z;
        coord_t corner_a_x;
        coord_t corner_a_y;
        coord_t corner_a_z;
        coord_t corner_b_x;
        coord_t corner_b_y;
        coord_t corner_b_z;
        coord_t corner_c_x;
        coord_t corner_c_y;
        coord_t corner_c_z;
    } pit_req_t;

    // result payload
    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } pit_rsp_t;

    // dot products of the edge vectors u, v and w
    typedef struct packed {
        dot_t uu;
        dot_t vv;
        dot_t uv;
        dot_t wu;
        dot_t wv;
    } pit_dots_t;

    // products of dot pairs used by the Lagrange identity
    typedef struct packed {
        wide_t uu_vv;
        wide_t uv_uv;
        wide_t uu_wv;
        wide_t uv_wu;
        wide_t wu_vv;
        wide_t wv_uv;
    } pit_prods_t;

endpackage

`default_nettype wire

// ===== src/pit_if.sv =====
// ----------------------------------------------------------------------------
// pit_if
// Valid/ready channels for point-in-triangle requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pit_req_if;
    logic              valid;
    logic              ready;
    pit_pkg::pit_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pit_rsp_if;
    logic              valid;
    logic              ready;
    pit_pkg::pit_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/pit_vec_front.sv =====
// ----------------------------------------------------------------------------
// pit_vec_front
// Stages 1 to 3: edge vectors u = B - A, v = C - A, w = P - A, their
// component products and the five dot products uu, vv, uv, wu, wv.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_vec_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vld_in,
    input  pit_pkg::pit_req_t  req_data,
    output logic               vld_out,
    output pit_pkg::pit_dots_t dots
);

    pit_pkg::coord_t pt [3];
    pit_pkg::coord_t ca [3];
    pit_pkg::coord_t cb [3];
    pit_pkg::coord_t cc [3];

    pit_pkg::diff_t u_next [3];
    pit_pkg::diff_t v_next [3];
    pit_pkg::diff_t w_next [3];
    pit_pkg::diff_t u_reg  [3];
    pit_pkg::diff_t v_reg  [3];
    pit_pkg::diff_t w_reg  [3];

    pit_pkg::prod_t p_uu_next [3];
    pit_pkg::prod_t p_vv_next [3];
    pit_pkg::prod_t p_uv_next [3];
    pit_pkg::prod_t p_wu_next [3];
    pit_pkg::prod_t p_wv_next [3];
    pit_pkg::prod_t p_uu_reg  [3];
    pit_pkg::prod_t p_vv_reg  [3];
    pit_pkg::prod_t p_uv_reg  [3];
    pit_pkg::prod_t p_wu_reg  [3];
    pit_pkg::prod_t p_wv_reg  [3];

    pit_pkg::pit_dots_t dots_next;
    pit_pkg::pit_dots_t dots_reg;

    logic vld1_reg;
    logic vld2_reg;
    logic vld3_reg;

    // unpack request into vectors
    assign pt[0] = req_data.test_x;
    assign pt[1] = req_data.test_y;
    assign pt[2] = req_data.test_z;
    assign ca[0] = req_data.corner_a_x;
    assign ca[1] = req_data.corner_a_y;
    assign ca[2] = req_data.corner_a_z;
    assign cb[0] = req_data.corner_b_x;
    assign cb[1] = req_data.corner_b_y;
    assign cb[2] = req_data.corner_b_z;
    assign cc[0] = req_data.corner_c_x;
    assign cc[1] = req_data.corner_c_y;
    assign cc[2] = req_data.corner_c_z;

    // stage 1: edge vectors relative to corner a
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = pit_pkg::diff_t'(cb[i]) - pit_pkg::diff_t'(ca[i]);
            v_next[i] = pit_pkg::diff_t'(cc[i]) - pit_pkg::diff_t'(ca[i]);
            w_next[i] = pit_pkg::diff_t'(pt[i]) - pit_pkg::diff_t'(ca[i]);
        end
    end

    // stage 2: component products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_uu_next[i] = pit_pkg::prod_t'(u_reg[i]) * pit_pkg::prod_t'(u_reg[i]);
            p_vv_next[i] = pit_pkg::prod_t'(v_reg[i]) * pit_pkg::prod_t'(v_reg[i]);
            p_uv_next[i] = pit_pkg::prod_t'(u_reg[i]) * pit_pkg::prod_t'(v_reg[i]);
            p_wu_next[i] = pit_pkg::prod_t'(w_reg[i]) * pit_pkg::prod_t'(u_reg[i]);
            p_wv_next[i] = pit_pkg::prod_t'(w_reg[i]) * pit_pkg::prod_t'(v_reg[i]);
        end
    end

    // stage 3: sum of three products per dot
    always_comb
    begin
        dots_next.uu = pit_pkg::dot_t'(p_uu_reg[0]) + pit_pkg::dot_t'(p_uu_reg[1])
                     + pit_pkg::dot_t'(p_uu_reg[2]);
        dots_next.vv = pit_pkg::dot_t'(p_vv_reg[0]) + pit_pkg::dot_t'(p_vv_reg[1])
                     + pit_pkg::dot_t'(p_vv_reg[2]);
        dots_next.uv = pit_pkg::dot_t'(p_uv_reg[0]) + pit_pkg::dot_t'(p_uv_reg[1])
                     + pit_pkg::dot_t'(p_uv_reg[2]);
        dots_next.wu = pit_pkg::dot_t'(p_wu_reg[0]) + pit_pkg::dot_t'(p_wu_reg[1])
                     + pit_pkg::dot_t'(p_wu_reg[2]);
        dots_next.wv = pit_pkg::dot_t'(p_wv_reg[0]) + pit_pkg::dot_t'(p_wv_reg[1])
                     + pit_pkg::dot_t'(p_wv_reg[2]);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i]    <= u_next[i];
                v_reg[i]    <= v_next[i];
                w_reg[i]    <= w_next[i];
                p_uu_reg[i] <= p_uu_next[i];
                p_vv_reg[i] <= p_vv_next[i];
                p_uv_reg[i] <= p_uv_next[i];
                p_wu_reg[i] <= p_wu_next[i];
                p_wv_reg[i] <= p_wv_next[i];
            end
            dots_reg <= dots_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    assign vld_out = vld3_reg;
    assign dots    = dots_reg;

endmodule

`default_nettype wire

// ===== src/pit_wide_mult.sv =====
// ----------------------------------------------------------------------------
// pit_wide_mult
// Two-stage signed multiply of two dot-product values: four half-width
// partial products, then a shifted sum into the wide result.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_wide_mult (
    input  logic                clk,
    input  logic                en,
    input  pit_pkg::dot_t       a,
    input  pit_pkg::dot_t       b,
    output pit_pkg::wide_t      p
);

    pit_pkg::half_t ah;
    pit_pkg::half_t al;
    pit_pkg::half_t bh;
    pit_pkg::half_t bl;

    pit_pkg::part_t hh_next;
    pit_pkg::part_t hl_next;
    pit_pkg::part_t lh_next;
    pit_pkg::part_t ll_next;
    pit_pkg::part_t hh_reg;
    pit_pkg::part_t hl_reg;
    pit_pkg::part_t lh_reg;
    pit_pkg::part_t ll_reg;

    pit_pkg::wide_t p_next;
    pit_pkg::wide_t p_reg;

    // split: signed high half, zero-extended low half
    assign ah = {a[pit_pkg::DOT_W-1], a[pit_pkg::DOT_W-1:pit_pkg::HALF_W]};
    assign al = {1'b0, a[pit_pkg::HALF_W-1:0]};
    assign bh = {b[pit_pkg::DOT_W-1], b[pit_pkg::DOT_W-1:pit_pkg::HALF_W]};
    assign bl = {1'b0, b[pit_pkg::HALF_W-1:0]};

    // partial products
    assign hh_next = pit_pkg::part_t'(ah) * pit_pkg::part_t'(bh);
    assign hl_next = pit_pkg::part_t'(ah) * pit_pkg::part_t'(bl);
    assign lh_next = pit_pkg::part_t'(al) * pit_pkg::part_t'(bh);
    assign ll_next = pit_pkg::part_t'(al) * pit_pkg::part_t'(bl);

    // recombine with half-width weights
    assign p_next = (pit_pkg::wide_t'(hh_reg) <<< (2 * pit_pkg::HALF_W))
                  + ((pit_pkg::wide_t'(hl_reg) + pit_pkg::wide_t'(lh_reg))
                     <<< pit_pkg::HALF_W)
                  + pit_pkg::wide_t'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== src/pit_prod_stage.sv =====
// ----------------------------------------------------------------------------
// pit_prod_stage
// Stages 4 and 5: the six products of dot pairs needed for d, the gamma
// numerator and the beta numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_prod_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  pit_pkg::pit_dots_t  dots,
    output logic                vld_out,
    output pit_pkg::pit_prods_t prods
);

    logic vld4_reg;
    logic vld5_reg;

    // (u.u)(v.v) and (u.v)^2 for d
    pit_wide_mult u_mul_uu_vv (.clk(clk), .en(en), .a(dots.uu), .b(dots.vv),
                               .p(prods.uu_vv));
    pit_wide_mult u_mul_uv_uv (.clk(clk), .en(en), .a(dots.uv), .b(dots.uv),
                               .p(prods.uv_uv));

    // (u.u)(w.v) and (u.v)(w.u) for the gamma numerator
    pit_wide_mult u_mul_uu_wv (.clk(clk), .en(en), .a(dots.uu), .b(dots.wv),
                               .p(prods.uu_wv));
    pit_wide_mult u_mul_uv_wu (.clk(clk), .en(en), .a(dots.uv), .b(dots.wu),
                               .p(prods.uv_wu));

    // (w.u)(v.v) and (w.v)(u.v) for the beta numerator
    pit_wide_mult u_mul_wu_vv (.clk(clk), .en(en), .a(dots.wu), .b(dots.vv),
                               .p(prods.wu_vv));
    pit_wide_mult u_mul_wv_uv (.clk(clk), .en(en), .a(dots.wv), .b(dots.uv),
                               .p(prods.wv_uv));

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else if (en)
        begin
            vld4_reg <= vld_in;
            vld5_reg <= vld4_reg;
        end
    end

    assign vld_out = vld5_reg;

endmodule

`default_nettype wire

// ===== src/pit_decide.sv =====
// ----------------------------------------------------------------------------
// pit_decide
// Stages 6 to 8: d, gamma and beta numerators by the Lagrange identity,
// then the range checks against d and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_decide (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  pit_pkg::pit_prods_t prods,
    output logic                vld_out,
    output pit_pkg::pit_rsp_t   rsp_data
);

    localparam int MSB = pit_pkg::WIDE_W - 1;

    pit_pkg::wide_t d_next;
    pit_pkg::wide_t g_next;
    pit_pkg::wide_t bn_next;
    pit_pkg::wide_t d6_reg;
    pit_pkg::wide_t g_reg;
    pit_pkg::wide_t bn_reg;

    pit_pkg::wide_t sum_next;
    pit_pkg::wide_t dmg;
    pit_pkg::wide_t dmb;
    logic           ok_next;
    logic           zero_next;
    pit_pkg::wide_t d7_reg;
    pit_pkg::wide_t sum_reg;
    logic           ok_reg;
    logic           zero_reg;

    pit_pkg::wide_t    dms;
    pit_pkg::pit_rsp_t rsp_next;
    pit_pkg::pit_rsp_t rsp_reg;

    logic vld6_reg;
    logic vld7_reg;
    logic vld8_reg;

    // stage 6: d = |u x v|^2, gamma and beta numerators
    assign d_next  = prods.uu_vv - prods.uv_uv;
    assign g_next  = prods.uu_wv - prods.uv_wu;
    assign bn_next = prods.wu_vv - prods.wv_uv;

    // stage 7: single-numerator bounds and the numerator sum
    assign sum_next  = g_reg + bn_reg;
    assign dmg       = d6_reg - g_reg;
    assign dmb       = d6_reg - bn_reg;
    assign ok_next   = !g_reg[MSB] && !bn_reg[MSB] && !dmg[MSB] && !dmb[MSB];
    assign zero_next = (d6_reg == '0);

    // stage 8: alpha bound and final flags
    assign dms = d7_reg - sum_reg;
    always_comb
    begin
        rsp_next.degenerate = zero_reg;
        rsp_next.inside_res = ok_reg && !sum_reg[MSB] && !dms[MSB] && !zero_reg;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d6_reg   <= d_next;
            g_reg    <= g_next;
            bn_reg   <= bn_next;
            d7_reg   <= d6_reg;
            sum_reg  <= sum_next;
            ok_reg   <= ok_next;
            zero_reg <= zero_next;
            rsp_reg  <= rsp_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
        end
        else if (en)
        begin
            vld6_reg <= vld_in;
            vld7_reg <= vld6_reg;
            vld8_reg <= vld7_reg;
        end
    end

    assign vld_out  = vld8_reg;
    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

// ===== src/point_in_triangle_test_core.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_test_core
// Barycentric point-in-triangle test in 3D, fully pipelined.
//
//   channel | dir | payload                                   | handshake
//   --------+-----+-------------------------------------------+------------
//   req     | in  | test point, corners a, b, c (24b signed)  | valid/ready
//   rsp     | out | inside_res, degenerate                    | valid/ready
//
// One request is taken every cycle unless a result is stalled on rsp.
// The pipeline has eight register stages: edge vectors, component
// products, dot sums, split partial products, wide products, numerators,
// bounds, output register.
// While a result waits on rsp the whole pipeline holds; nothing is dropped.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_triangle_test_core (
    input  logic            clk,
    input  logic            rst_n,
    pit_req_if.sink         req,
    pit_rsp_if.source       rsp
);

    logic                en;
    logic                front_vld;
    pit_pkg::pit_dots_t  dots;
    logic                prod_vld;
    pit_pkg::pit_prods_t prods;
    logic                out_vld;
    pit_pkg::pit_rsp_t   out_data;

    // pipeline advances unless a result is stalled at the output
    assign en        = !out_vld || rsp.ready;
    assign req.ready = en;

    pit_vec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (req.valid),
        .req_data (req.data),
        .vld_out  (front_vld),
        .dots     (dots)
    );

    pit_prod_stage u_prod (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (front_vld),
        .dots    (dots),
        .vld_out (prod_vld),
        .prods   (prods)
    );

    pit_decide u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (prod_vld),
        .prods    (prods),
        .vld_out  (out_vld),
        .rsp_data (out_data)
    );

    assign rsp.valid = out_vld;
    assign rsp.data  = out_data;

endmodule

`default_nettype wire

// ===== src/pit_checker.sv =====
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks for the point-in-triangle core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_inside,
    input logic rsp_degenerate
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its flags
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable({rsp_inside, rsp_degenerate}))
        else $error("result changed while stalled");

    // a degenerate triangle never reports inside
    a_degen_outside: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_degenerate |-> !rsp_inside)
        else $error("inside set on degenerate triangle");

    // request side is open exactly when the output is free to move
    a_req_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("request ready does not follow output stall");

    // a request is never blocked while the output is empty
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !rsp_valid |-> req_ready)
        else $error("request blocked with empty output");

endmodule

bind point_in_triangle_test_core pit_checker u_pit_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_inside     (rsp.data.inside_res),
    .rsp_degenerate (rsp.data.degenerate)
);

`default_nettype wire
